### hw/rtl/ifmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, codes and character helpers of the integer-to-ascii formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  // number base codes as carried on the input channel
  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2,
    BASE_RSV = 2'd3
  } base_sel_t;

  // sequencer phases
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // operations of the shared digit unit
  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_CLEAR,
    DOP_LOAD_HEX,
    DOP_LOAD_OCT,
    DOP_DABBLE,
    DOP_SHIFT
  } dop_t;

  // command from the sequencer to the digit unit
  typedef struct packed {
    dop_t op;
    logic bit_in;
  } dunit_cmd_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  // ascii for one digit 0..15
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (lower) begin
      c = CH_LOWER_A + {4'd0, d - 4'd10};
    end else begin
      c = CH_UPPER_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

### hw/rtl/ifmt_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt channels
// Valid/ready channel interfaces for operands in and characters out.
// ----------------------------------------------------------------------------
interface ifmt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        is_signed;
  logic [1:0]  num_base;
  logic [5:0]  field_width;
  logic        zero_pad;
  logic        lower_case;

  modport source (output valid, value, is_signed, num_base, field_width, zero_pad,
                  lower_case, input ready);
  modport sink   (input valid, value, is_signed, num_base, field_width, zero_pad,
                  lower_case, output ready);
endinterface

interface ifmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

### hw/rtl/ifmt_digit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt_digit_unit
// Digit register with one shared step: clear, load hex/octal digits,
// double-dabble one bit for decimal, or shift out the top digit.
// ----------------------------------------------------------------------------
module ifmt_digit_unit #(
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 22
) (
  input  logic                    clk,
  input  ifmt_pkg::dunit_cmd_t    cmd,
  input  logic [VALUE_BITS-1:0]   load_value,
  output logic [3:0]              top_digit
);

  localparam int DIG_W = 4 * DIGITS;
  localparam int OCT_W = 3 * DIGITS;

  logic [DIG_W-1:0] dig;
  logic [DIG_W-1:0] dig_next;
  logic [DIG_W-1:0] hex_load;
  logic [OCT_W-1:0] oct_bits;
  logic [DIG_W-1:0] oct_load;
  logic [DIG_W-1:0] adj;

  assign hex_load = DIG_W'(load_value);
  assign oct_bits = OCT_W'(load_value);

  // spread 3-bit groups into 4-bit digit slots
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      oct_load[4*k +: 4] = {1'b0, oct_bits[3*k +: 3]};
    end
  end

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[4*k +: 4] = (dig[4*k +: 4] >= 4'd5) ? dig[4*k +: 4] + 4'd3 : dig[4*k +: 4];
    end
  end

  // operation select
  always_comb begin
    case (cmd.op)
      ifmt_pkg::DOP_HOLD:     dig_next = dig;
      ifmt_pkg::DOP_CLEAR:    dig_next = '0;
      ifmt_pkg::DOP_LOAD_HEX: dig_next = hex_load;
      ifmt_pkg::DOP_LOAD_OCT: dig_next = oct_load;
      ifmt_pkg::DOP_DABBLE:   dig_next = {adj[DIG_W-2:0], cmd.bit_in};
      ifmt_pkg::DOP_SHIFT:    dig_next = {dig[DIG_W-5:0], 4'd0};
      default:                dig_next = dig;
    endcase
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
  end

  assign top_digit = dig[DIG_W-1 -: 4];

endmodule

### hw/rtl/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats one integer as a printf-style padded ascii field, one char per
// transfer.
// ----------------------------------------------------------------------------
// Usage: an operand transfer on in_ch carries value, is_signed, num_base,
// field_width, zero_pad and lower_case. The field comes out on out_ch one
// character per transfer, last set on the final character. The field is
// optional spaces, optional '-', optional zeros, then the digits.
// Steps per operand: the accept, then binary to bcd conversion for decimal
// (none for octal or hex), then skipping leading zero digits and setting
// up the padding, then the characters, max(width, sign + digits) of them.
// All digit work runs through one shared digit register unit.
// in_ch.ready is high only while the sequencer is idle; a new operand is
// taken while the final character still waits in the output register.
// A stall on out_ch holds the output register and pauses the emit phase.
// Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_WIDTH  = 63
) (
  input  logic        clk,
  input  logic        rst,
  ifmt_in_if.sink     in_ch,
  ifmt_out_if.source  out_ch
);

  localparam int DIGITS = (VALUE_BITS + 2) / 3;
  localparam int ND_W   = $clog2(DIGITS + 1);
  localparam int CNT_W  = $clog2(VALUE_BITS);

  ifmt_pkg::state_t     state, state_next;
  ifmt_pkg::dunit_cmd_t cmd;

  logic [VALUE_BITS-1:0] mag, mag_next;
  logic [CNT_W-1:0]      bit_cnt, bit_cnt_next;
  logic [ND_W-1:0]       nd, nd_next;
  logic                  neg, neg_next;
  logic                  zpad, zpad_next;
  logic                  lower, lower_next;
  logic [5:0]            wdt, wdt_next;
  logic [5:0]            pad_cnt, pad_cnt_next;
  logic                  out_valid, out_valid_next;
  logic [7:0]            out_char, out_char_next;
  logic                  out_last, out_last_next;

  logic [VALUE_BITS-1:0] in_val;
  logic                  in_dec;
  logic                  in_neg;
  logic [3:0]            top_digit;
  logic                  out_free;
  logic [6:0]            len;

  assign in_val = in_ch.value[VALUE_BITS-1:0];
  assign in_dec = (ifmt_pkg::base_sel_t'(in_ch.num_base) != ifmt_pkg::BASE_OCT) &&
                  (ifmt_pkg::base_sel_t'(in_ch.num_base) != ifmt_pkg::BASE_HEX);
  assign in_neg = in_dec && in_ch.is_signed && in_val[VALUE_BITS-1];
  assign out_free = !out_valid || out_ch.ready;
  assign len = 7'(nd) + 7'(neg);

  ifmt_digit_unit #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_digit (
    .clk        (clk),
    .cmd        (cmd),
    .load_value (in_val),
    .top_digit  (top_digit)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    mag_next       = mag;
    bit_cnt_next   = bit_cnt;
    nd_next        = nd;
    neg_next       = neg;
    zpad_next      = zpad;
    lower_next     = lower;
    wdt_next       = wdt;
    pad_cnt_next   = pad_cnt;
    out_valid_next = out_valid && !out_ch.ready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    cmd.op         = ifmt_pkg::DOP_HOLD;
    cmd.bit_in     = mag[VALUE_BITS-1];

    case (state)
      ifmt_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          neg_next     = in_neg;
          mag_next     = in_neg ? (~in_val + 1'b1) : in_val;
          zpad_next    = in_ch.zero_pad;
          lower_next   = in_ch.lower_case;
          wdt_next     = (in_ch.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH)
                                                             : in_ch.field_width;
          bit_cnt_next = CNT_W'(VALUE_BITS - 1);
          nd_next      = ND_W'(DIGITS);
          if (in_dec) begin
            cmd.op     = ifmt_pkg::DOP_CLEAR;
            state_next = ifmt_pkg::ST_CONVERT;
          end else begin
            cmd.op     = (ifmt_pkg::base_sel_t'(in_ch.num_base) == ifmt_pkg::BASE_HEX)
                         ? ifmt_pkg::DOP_LOAD_HEX : ifmt_pkg::DOP_LOAD_OCT;
            state_next = ifmt_pkg::ST_SCAN;
          end
        end
      end

      // one bit of binary to bcd per cycle
      ifmt_pkg::ST_CONVERT: begin
        cmd.op   = ifmt_pkg::DOP_DABBLE;
        mag_next = {mag[VALUE_BITS-2:0], 1'b0};
        if (bit_cnt == '0) begin
          state_next = ifmt_pkg::ST_SCAN;
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end

      // drop leading zero digits, keep at least one
      ifmt_pkg::ST_SCAN: begin
        if (nd == ND_W'(1) || top_digit != 4'd0) begin
          pad_cnt_next = ({1'b0, wdt} > len) ? 6'({1'b0, wdt} - len) : 6'd0;
          state_next   = ifmt_pkg::ST_EMIT;
        end else begin
          cmd.op  = ifmt_pkg::DOP_SHIFT;
          nd_next = nd - 1'b1;
        end
      end

      // one character into the output register per free cycle
      ifmt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_last_next  = 1'b0;
          if (!zpad && pad_cnt != 6'd0) begin
            out_char_next = ifmt_pkg::CH_SPACE;
            pad_cnt_next  = pad_cnt - 1'b1;
          end else if (neg) begin
            out_char_next = ifmt_pkg::CH_MINUS;
            neg_next      = 1'b0;
          end else if (pad_cnt != 6'd0) begin
            out_char_next = ifmt_pkg::CH_ZERO;
            pad_cnt_next  = pad_cnt - 1'b1;
          end else begin
            out_char_next = ifmt_pkg::digit_char(top_digit, lower);
            cmd.op        = ifmt_pkg::DOP_SHIFT;
            nd_next       = nd - 1'b1;
            if (nd == ND_W'(1)) begin
              out_last_next = 1'b1;
              state_next    = ifmt_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_next = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ifmt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    mag      <= mag_next;
    bit_cnt  <= bit_cnt_next;
    nd       <= nd_next;
    neg      <= neg_next;
    zpad     <= zpad_next;
    lower    <= lower_next;
    wdt      <= wdt_next;
    pad_cnt  <= pad_cnt_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  assign in_ch.ready     = (state == ifmt_pkg::ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.out_char = out_char;
  assign out_ch.last     = out_last;

endmodule
